[hw/rtl/brla_pkg.sv]
// Shared types, codes and widths for the brightness limit request arbiter.
`timescale 1ns / 1ps

package brla_pkg;

  // Field widths
  localparam int IDX_W      = 8;
  localparam int REQR_W     = 4;
  localparam int TYPE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Stream widths, tdata padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = TYPE_W;
  localparam int OUT_TDATA_W = 24;

  // Default slot count
  localparam int REQUESTERS_DEF = 16;

  typedef logic [TYPE_W-1:0]    req_type_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Request kinds
  localparam req_type_t REQ_LIMIT   = 2'd0;
  localparam req_type_t REQ_UNLIMIT = 2'd1;
  localparam req_type_t REQ_COMMIT  = 2'd2;
  localparam req_type_t REQ_CLEAR   = 2'd3;

  // Register indexes
  localparam cfg_idx_t CFG_SUPPORTED = 2'd0;
  localparam cfg_idx_t CFG_UPPER     = 2'd1;
  localparam cfg_idx_t CFG_LOWER     = 2'd2;
  localparam cfg_idx_t CFG_USER_PREF = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the input beat
    logic scan_step;  // read the next slot of the commit scan
    logic exec;       // apply the operation and load the output register
  } brla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_type_t req_type;   // captured request kind
    logic      scan_last;  // scan reads the final slot this cycle
    logic      out_free;   // output register can take a result
  } brla_sts_t;

endpackage

[hw/rtl/brla_ctrl.sv]
// Sequencing state machine for the brightness limit request arbiter.
`timescale 1ns / 1ps

module brla_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  brla_pkg::brla_sts_t sts,
  output brla_pkg::brla_cmd_t cmd
);
  import brla_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Decode state into commands and next state
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.req_type == REQ_COMMIT) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Only one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_step, cmd.exec}))
    else $error("brla_ctrl: more than one command at once");

  // A scan is never entered for anything but a commit
  a_scan_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> sts.req_type == REQ_COMMIT)
    else $error("brla_ctrl: scan for a non-commit request");

  // Execute never overwrites a waiting result
  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> sts.out_free)
    else $error("brla_ctrl: execute while output register busy");

endmodule

[hw/rtl/brla_dp.sv]
// Datapath: configuration, request slot table, commit scan and output register.
`timescale 1ns / 1ps

module brla_dp #(
  parameter int REQUESTERS = brla_pkg::REQUESTERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  brla_pkg::cfg_idx_t           cfg_index,
  input  logic [brla_pkg::CFG_DATA_W-1:0] cfg_data,
  // input item
  input  brla_pkg::req_type_t          in_type,
  input  logic [brla_pkg::REQR_W-1:0]  in_reqr,
  // result
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [brla_pkg::IDX_W-1:0]   out_req_idx,
  output logic                         out_act,
  output logic [brla_pkg::IDX_W-1:0]   out_applied,
  // control
  input  brla_pkg::brla_cmd_t          cmd,
  output brla_pkg::brla_sts_t          sts
);
  import brla_pkg::*;

  localparam int SLOT_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int EXT_W  = 9;

  typedef logic [IDX_W-1:0] idx_t;

  // Configuration registers
  logic sup_r;
  idx_t upper_r;
  idx_t lower_r;
  idx_t pref_r;

  // Request state
  logic [REQUESTERS-1:0] slot_vld_r;
  idx_t                  slot_mem [REQUESTERS];
  logic                  hbl_r;
  idx_t                  applied_r;

  // Captured item and scan state
  req_type_t          type_r;
  logic [REQR_W-1:0]  reqr_r;
  logic [SLOT_W-1:0]  cnt_r;
  logic               acc_en_r;
  idx_t               best_r;
  idx_t               rd_data_r;
  logic               rd_vld_r;

  // Output register
  logic out_vld_r;
  idx_t out_req_r;
  logic out_act_r;
  idx_t out_app_r;

  // Slot decode
  logic [EXT_W-1:0]  reqr_ext;
  logic [SLOT_W-1:0] slot;
  logic              slot_ok;
  logic [SLOT_W-1:0] rd_addr;

  // Execute results
  idx_t cur;
  idx_t pref_max;
  idx_t nxt;
  idx_t req_out;
  logic act;
  logic wr_en;
  logic vld_set;
  logic vld_clr;
  logic clr_all;
  logic hbl_set;
  logic hbl_clr;
  logic app_ld;

  assign reqr_ext = EXT_W'(reqr_r);
  assign slot     = reqr_ext[SLOT_W-1:0];
  assign slot_ok  = reqr_ext < EXT_W'(REQUESTERS);
  assign rd_addr  = cmd.scan_step ? cnt_r : slot;

  // Status to controller
  assign sts.req_type  = type_r;
  assign sts.scan_last = cnt_r == SLOT_W'(REQUESTERS - 1);
  assign sts.out_free  = !out_vld_r || out_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r   <= 1'b0;
      upper_r <= '0;
      lower_r <= '1;
      pref_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SUPPORTED: sup_r   <= cfg_data[0];
        CFG_UPPER:     upper_r <= cfg_data[IDX_W-1:0];
        CFG_LOWER:     lower_r <= cfg_data[IDX_W-1:0];
        CFG_USER_PREF: pref_r  <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture item, step scan counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_type;
      reqr_r <= in_reqr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.scan_step;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.scan_step && !sts.scan_last) begin
        cnt_r <= cnt_r + SLOT_W'(1);
      end
    end
  end

  // Read one slot per cycle, registered
  always_ff @(posedge clk) begin
    rd_data_r <= slot_mem[rd_addr];
    rd_vld_r  <= slot_vld_r[rd_addr];
  end

  // Track the running maximum of the commit scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_r <= upper_r;
    end else if (acc_en_r && rd_vld_r && (rd_data_r > best_r)) begin
      best_r <= rd_data_r;
    end
  end

  // Work out the operation
  always_comb begin
    cur      = rd_vld_r ? rd_data_r : upper_r;
    pref_max = (pref_r > upper_r) ? pref_r : upper_r;
    nxt      = cur;
    req_out  = '0;
    act      = 1'b0;
    wr_en    = 1'b0;
    vld_set  = 1'b0;
    vld_clr  = 1'b0;
    clr_all  = 1'b0;
    hbl_set  = 1'b0;
    hbl_clr  = 1'b0;
    app_ld   = 1'b0;
    case (type_r)
      REQ_LIMIT: begin
        req_out = upper_r;
        if (slot_ok) begin
          req_out = cur;
          if (sup_r && (cur < lower_r)) begin
            if (!hbl_r) begin
              if (applied_r < upper_r) begin
                nxt = upper_r;
              end else if (applied_r > lower_r) begin
                nxt = applied_r;
              end else begin
                nxt = (applied_r == '1) ? applied_r : applied_r + idx_t'(1);
              end
            end else begin
              nxt = (cur == '1) ? cur : cur + idx_t'(1);
            end
            wr_en   = 1'b1;
            vld_set = 1'b1;
            act     = 1'b1;
            req_out = nxt;
          end
        end
      end
      REQ_UNLIMIT: begin
        req_out = upper_r;
        if (slot_ok) begin
          if (sup_r && hbl_r && (cur > upper_r)) begin
            nxt     = (cur == pref_max) ? upper_r : cur - idx_t'(1);
            wr_en   = 1'b1;
            vld_set = 1'b1;
            act     = 1'b1;
            req_out = nxt;
          end else begin
            hbl_clr = sup_r && hbl_r;
            vld_clr = 1'b1;
          end
        end
      end
      REQ_COMMIT: begin
        if (sup_r) begin
          req_out = best_r;
          if (applied_r != best_r) begin
            app_ld  = 1'b1;
            hbl_set = 1'b1;
            act     = 1'b1;
          end else if (hbl_r && (applied_r <= upper_r)) begin
            hbl_clr = 1'b1;
          end
        end else begin
          req_out = applied_r;
        end
      end
      default: begin
        clr_all = 1'b1;
      end
    endcase
  end

  // Slot table write
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slot_mem[slot] <= nxt;
    end
  end

  // Slot valid bits and limiting state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      hbl_r      <= 1'b0;
      applied_r  <= '0;
    end else if (cmd.exec) begin
      if (clr_all) begin
        slot_vld_r <= '0;
      end else if (vld_set) begin
        slot_vld_r[slot] <= 1'b1;
      end else if (vld_clr) begin
        slot_vld_r[slot] <= 1'b0;
      end
      if (hbl_set) begin
        hbl_r <= 1'b1;
      end else if (hbl_clr) begin
        hbl_r <= 1'b0;
      end
      if (app_ld) begin
        applied_r <= best_r;
      end
    end
  end

  // Output register: load on execute, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.exec) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_req_r <= req_out;
      out_act_r <= act;
      out_app_r <= app_ld ? best_r : applied_r;
    end
  end

  assign out_tvalid  = out_vld_r;
  assign out_req_idx = out_req_r;
  assign out_act     = out_act_r;
  assign out_applied = out_app_r;

  // A result is presented right after execute
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_vld_r)
    else $error("brla_dp: result missing after execute");

  // A changing commit marks the display as limited
  a_commit_hbl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && app_ld |=> hbl_r && (applied_r == $past(best_r)))
    else $error("brla_dp: commit did not apply the maximum");

  // The applied index changes only through a commit
  a_applied_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && app_ld) |=> $stable(applied_r))
    else $error("brla_dp: applied index changed outside commit");

endmodule

[hw/rtl/brightness_limit_request_arbiter_unit.sv]
// Top level of the brightness limit request arbiter.
`timescale 1ns / 1ps

// Arbitrates display brightness limit requests from REQUESTERS slots (a higher
// index throttles more). Each input beat is a limit, unlimit, commit or
// clear-all request, and each gives exactly one result beat. Limit, unlimit
// and clear-all pass from acceptance to the result register through accept,
// slot table read and execute; commit adds a maximum search over the
// single-port slot table, which it walks one slot per cycle, and a drain step.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is taken. Configuration writes are always
// ready and belong in idle periods. The slot table needs no clearing pass.
module brightness_limit_request_arbiter_unit #(
  parameter int REQUESTERS = brla_pkg::REQUESTERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [brla_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] requester, [7:4] zero
  input  logic [brla_pkg::IN_TUSER_W-1:0]   in_tuser,   // [1:0] req_type
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [brla_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] request_index,
                                                        // [8] action_taken,
                                                        // [16:9] applied_index,
                                                        // [23:17] zero
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  brla_pkg::cfg_idx_t                cfg_index,
  input  logic [brla_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import brla_pkg::*;

  brla_cmd_t cmd;
  brla_sts_t sts;

  logic [IDX_W-1:0] out_req_idx;
  logic             out_act;
  logic [IDX_W-1:0] out_applied;

  assign cfg_ready = 1'b1;

  brla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brla_dp #(
    .REQUESTERS (REQUESTERS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_type     (in_tuser[TYPE_W-1:0]),
    .in_reqr     (in_tdata[REQR_W-1:0]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_req_idx (out_req_idx),
    .out_act     (out_act),
    .out_applied (out_applied),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Pack the result beat
  assign out_tdata = {{(OUT_TDATA_W - 2 * IDX_W - 1){1'b0}}, out_applied, out_act, out_req_idx};

endmodule
